// ===== rtl/ssrc_pkg.sv =====
// Shared types, constants and event codes for the shadow return-address stack checker.
// No dependencies; imported by every module of the block except ssrc_ram.
package ssrc_pkg;

    localparam int STACK_DEPTH_DEF = 8192;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int FUNC_W       = 3;
    localparam int ADDR_W       = 64;
    localparam int DEPTH_W      = 14;
    localparam int COUNT_W      = 32;
    localparam int NUM_COUNTERS = 5;

    localparam logic [FUNC_W-1:0] CODE_WARN   = 3'd0;
    localparam logic [FUNC_W-1:0] CODE_CALL_A = 3'd1;
    localparam logic [FUNC_W-1:0] CODE_CALL_B = 3'd2;
    localparam logic [FUNC_W-1:0] CODE_RET_A  = 3'd3;
    localparam logic [FUNC_W-1:0] CODE_RET_B  = 3'd4;

    // counter slot that holds the warning count
    localparam logic [FUNC_W-1:0] CNT_WARN = 3'd0;

    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_WARN,
        KIND_PUSH,
        KIND_POP,
        KIND_BAD
    } item_kind_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_READ
    } back_state_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [FUNC_W-1:0]   func;
        logic [ADDR_W-1:0]   address;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/ssrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ssrc_front.sv =====
// Front end: accepts trace events and sorts them into push, pop, warning or bad.
// Depends on ssrc_pkg.
module ssrc_front
    import ssrc_pkg::*;
(
    input  logic                start,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ADDR_W-1:0]   address,
    input  queue_status_t       q_status,
    output logic                busy,
    output logic                q_push,
    output queue_item_t         q_item
);

    item_kind_t kind;

    always_comb
    begin
        case (func)
            CODE_WARN:               kind = KIND_WARN;
            CODE_CALL_A, CODE_CALL_B: kind = KIND_PUSH;
            CODE_RET_A, CODE_RET_B:   kind = KIND_POP;
            default:                 kind = KIND_BAD;
        endcase
    end

    assign busy           = q_status.full;
    assign q_push         = start && !q_status.full;
    assign q_item.kind    = kind;
    assign q_item.func    = func;
    assign q_item.address = address;

endmodule

// ===== rtl/ssrc_queue.sv =====
// Short FIFO of classified events between the front and back ends.
// Depends on ssrc_pkg.
module ssrc_queue
    import ssrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_item_t   push_item,
    input  logic          pop,
    output queue_item_t   head_item,
    output queue_status_t status
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    queue_item_t    slot_reg [QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    function automatic logic [QW-1:0] bump(input logic [QW-1:0] p);
        if (p == QW'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/ssrc_back.sv =====
// Back end: stack pointer, stack RAM, event counters and the result registers.
// Depends on ssrc_pkg and ssrc_ram.
module ssrc_back
    import ssrc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  queue_item_t         head_item,
    input  queue_status_t       q_status,
    output logic                q_pop,
    output logic                done,
    output logic [ADDR_W-1:0]   popped_address,
    output logic                mismatch,
    output logic                overflow,
    output logic                underflow,
    output logic                bad_code,
    output logic [DEPTH_W-1:0]  depth,
    output logic [COUNT_W-1:0]  count_code_one,
    output logic [COUNT_W-1:0]  count_code_two,
    output logic [COUNT_W-1:0]  count_code_three,
    output logic [COUNT_W-1:0]  count_code_four,
    output logic [COUNT_W-1:0]  warning_count
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    back_state_t        state_reg, state_next;
    logic [PW-1:0]      sp_reg, sp_next;
    logic [COUNT_W-1:0] cnt_reg [NUM_COUNTERS];
    logic [COUNT_W-1:0] cnt_next [NUM_COUNTERS];
    logic [ADDR_W-1:0]  hold_reg, hold_next;

    logic               done_reg, done_next;
    logic [ADDR_W-1:0]  popped_reg, popped_next;
    logic               mism_reg, mism_next;
    logic               ovf_reg, ovf_next;
    logic               unf_reg, unf_next;
    logic               bad_reg, bad_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ADDR_W-1:0]  ram_rdata;
    logic [PW-1:0]      sp_dec;

    assign sp_dec = sp_reg - 1'b1;

    ssrc_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (head_item.address),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        cnt_next    = cnt_reg;
        hold_next   = hold_reg;
        done_next   = 1'b0;
        popped_next = popped_reg;
        mism_next   = mism_reg;
        ovf_next    = ovf_reg;
        unf_next    = unf_reg;
        bad_next    = bad_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = sp_reg[AW-1:0];
        ram_raddr   = sp_dec[AW-1:0];

        case (state_reg)
            BACK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop       = 1'b1;
                    popped_next = '0;
                    mism_next   = 1'b0;
                    ovf_next    = 1'b0;
                    unf_next    = 1'b0;
                    bad_next    = 1'b0;
                    done_next   = 1'b1;
                    if (head_item.kind != KIND_BAD)
                    begin
                        cnt_next[head_item.func] = cnt_reg[head_item.func] + 1'b1;
                    end
                    case (head_item.kind)
                        KIND_BAD:
                        begin
                            bad_next = 1'b1;
                        end
                        KIND_PUSH:
                        begin
                            if (sp_reg == PW'(STACK_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ram_we  = 1'b1;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (sp_reg == '0)
                            begin
                                unf_next    = 1'b1;
                                popped_next = ALL_ONES;
                                if (head_item.address != ALL_ONES)
                                begin
                                    mism_next          = 1'b1;
                                    cnt_next[CNT_WARN] = cnt_reg[CNT_WARN] + 1'b1;
                                end
                            end
                            else
                            begin
                                // result waits in BACK_READ for the registered RAM read
                                ram_re     = 1'b1;
                                sp_next    = sp_dec;
                                hold_next  = head_item.address;
                                done_next  = 1'b0;
                                state_next = BACK_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BACK_READ:
            begin
                done_next   = 1'b1;
                popped_next = ram_rdata;
                mism_next   = (ram_rdata != hold_reg);
                if (ram_rdata != hold_reg)
                begin
                    cnt_next[CNT_WARN] = cnt_reg[CNT_WARN] + 1'b1;
                end
                state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            sp_reg    <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        popped_reg <= popped_next;
        mism_reg   <= mism_next;
        ovf_reg    <= ovf_next;
        unf_reg    <= unf_next;
        bad_reg    <= bad_next;
    end

    assign done             = done_reg;
    assign popped_address   = popped_reg;
    assign mismatch         = mism_reg;
    assign overflow         = ovf_reg;
    assign underflow        = unf_reg;
    assign bad_code         = bad_reg;
    assign depth            = DEPTH_W'(sp_reg);
    assign count_code_one   = cnt_reg[1];
    assign count_code_two   = cnt_reg[2];
    assign count_code_three = cnt_reg[3];
    assign count_code_four  = cnt_reg[4];
    assign warning_count    = cnt_reg[0];

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BACK_READ |=> done_reg && !unf_reg && !ovf_reg && !bad_reg)
        else $error("RAM read did not produce a pop result");

    a_no_pop_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BACK_READ |-> !q_pop)
        else $error("queue popped while waiting on RAM");

    a_unf_ones: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && unf_reg |-> popped_reg == ALL_ONES && sp_reg == '0)
        else $error("underflow result inconsistent");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && ovf_reg |-> sp_reg == PW'(STACK_DEPTH) && !mism_reg)
        else $error("overflow result with stack not full");
`endif

endmodule

// ===== rtl/shadow_stack_return_checker_unit.sv =====
// Top level of the shadow return-address stack checker: front, queue and back ends.
// Depends on ssrc_pkg, ssrc_front, ssrc_queue, ssrc_back (and ssrc_ram below it).
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  event in | start / busy       | func, address
//  result   | done (1-cycle)     | popped_address, mismatch, overflow, underflow,
//           |                    | bad_code, depth, count_code_*, warning_count
//
// Each accepted event gives one result. The event waits in the event queue; the back end
// takes it from the queue head and registers the result, and a return that pops a
// non-empty stack also waits for the registered read of the stack RAM. The back end
// retires one event per cycle while idle, but a pop with data holds it in BACK_READ for
// the RAM read; busy rises when the 2-entry event queue is full.
// Reset clears the stack pointer and counters; the stack RAM is not cleared.
// The receiver cannot stall: results are shown for one cycle only.
module shadow_stack_return_checker_unit
    import ssrc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ADDR_W-1:0]   address,
    output logic                done,
    output logic [ADDR_W-1:0]   popped_address,
    output logic                mismatch,
    output logic                overflow,
    output logic                underflow,
    output logic                bad_code,
    output logic [DEPTH_W-1:0]  depth,
    output logic [COUNT_W-1:0]  count_code_one,
    output logic [COUNT_W-1:0]  count_code_two,
    output logic [COUNT_W-1:0]  count_code_three,
    output logic [COUNT_W-1:0]  count_code_four,
    output logic [COUNT_W-1:0]  warning_count
);

    queue_status_t q_status;
    queue_item_t   q_in_item;
    queue_item_t   q_head_item;
    logic          q_push;
    logic          q_pop;

    ssrc_front u_front (
        .start    (start),
        .func     (func),
        .address  (address),
        .q_status (q_status),
        .busy     (busy),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    ssrc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .status    (q_status)
    );

    ssrc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_item        (q_head_item),
        .q_status         (q_status),
        .q_pop            (q_pop),
        .done             (done),
        .popped_address   (popped_address),
        .mismatch         (mismatch),
        .overflow         (overflow),
        .underflow        (underflow),
        .bad_code         (bad_code),
        .depth            (depth),
        .count_code_one   (count_code_one),
        .count_code_two   (count_code_two),
        .count_code_three (count_code_three),
        .count_code_four  (count_code_four),
        .warning_count    (warning_count)
    );

endmodule
